### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define VEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define VEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/vec_pkg.sv
// Types, constants and codes of the edge colorer.
package vec_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int VTX_W        = 9;
    localparam int COL_W        = 9;
    localparam int PAIR_AW      = VTX_W + COL_W;
    localparam int SMALL_AW     = 9;
    localparam int FAN_DW       = VTX_W + COL_W;
    localparam int TOP_COLOR    = MAX_VERTICES + 1;
    localparam int FAN_MAX      = MAX_VERTICES + 2;
    localparam int TRIES_MAX    = 4 * FAN_MAX;
    localparam int STEPS_MAX    = 2 * FAN_MAX;
    localparam int TRIES_W      = 11;
    localparam int STEPS_W      = 10;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } vec_mode_t;

    typedef enum logic [1:0] {
        PB_CHAIN,
        PB_FAN,
        PB_LAST
    } vec_pb_kind_t;

    typedef enum logic [5:0] {
        ST_SWEEP, ST_IDLE, ST_DECODE, ST_TOP_CHK,
        ST_TRY, ST_UNDO_R, ST_UNDO_W, ST_TRY_F, ST_TRY_F2,
        ST_FAN_E, ST_FAN_E2, ST_FAN_D, ST_FAN_D2, ST_FAN_N1, ST_FAN_N2, ST_FAN_S,
        ST_PB_R, ST_PB_C, ST_PB_RET,
        ST_P_RD, ST_P_E1, ST_P_E2, ST_P_N1, ST_P_N2, ST_P_N3, ST_P_N4,
        ST_P_F1, ST_P_F2,
        ST_R_CHK, ST_R_D, ST_R_W,
        ST_FLIP, ST_FL_CHK, ST_FL_A, ST_FL_B, ST_FL_W2, ST_FL_E1, ST_FL_E2,
        ST_AFT, ST_AFT2, ST_SR_R, ST_SR_C,
        ST_FINAL, ST_FIN2, ST_DONE
    } vec_state_t;

    typedef struct packed {
        logic                e_re;
        logic [PAIR_AW-1:0]  e_raddr;
        logic                e_we;
        logic [PAIR_AW-1:0]  e_waddr;
        logic [COL_W-1:0]    e_wdata;
        logic                n_re;
        logic [PAIR_AW-1:0]  n_raddr;
        logic                n_we;
        logic [PAIR_AW-1:0]  n_waddr;
        logic [VTX_W-1:0]    n_wdata;
        logic                f_re;
        logic [SMALL_AW-1:0] f_raddr;
        logic                f_we;
        logic [SMALL_AW-1:0] f_waddr;
        logic [COL_W-1:0]    f_wdata;
        logic                fan_re;
        logic [SMALL_AW-1:0] fan_raddr;
        logic                fan_we;
        logic [SMALL_AW-1:0] fan_waddr;
        logic [FAN_DW-1:0]   fan_wdata;
        logic                s_re;
        logic [SMALL_AW-1:0] s_raddr;
        logic                s_we;
        logic [SMALL_AW-1:0] s_waddr;
        logic                s_wdata;
    } vec_mem_req_t;

    typedef struct packed {
        logic [COL_W-1:0]  e_rdata;
        logic [VTX_W-1:0]  n_rdata;
        logic [COL_W-1:0]  f_rdata;
        logic [FAN_DW-1:0] fan_rdata;
        logic              s_rdata;
    } vec_mem_rsp_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] color;
        logic [COL_W-1:0] max_color;
        logic             status;
    } vec_res_t;

    function automatic logic [PAIR_AW-1:0] pair_addr(input logic [VTX_W-1:0] hi,
                                                     input logic [COL_W-1:0] lo);
        pair_addr = {hi, lo};
    endfunction

endpackage

### hw/rtl/vec_mem.sv
// Edge colour, neighbour, free colour, fan and seen-colour memories.
module vec_mem (
    input  logic                 aclk,
    input  vec_pkg::vec_mem_req_t req,
    output vec_pkg::vec_mem_rsp_t rsp
);

    logic [vec_pkg::COL_W-1:0]  e_mem   [0:(2**vec_pkg::PAIR_AW)-1];
    logic [vec_pkg::VTX_W-1:0]  n_mem   [0:(2**vec_pkg::PAIR_AW)-1];
    logic [vec_pkg::COL_W-1:0]  f_mem   [0:(2**vec_pkg::SMALL_AW)-1];
    logic [vec_pkg::FAN_DW-1:0] fan_mem [0:(2**vec_pkg::SMALL_AW)-1];
    logic                       s_mem   [0:(2**vec_pkg::SMALL_AW)-1];

    logic [vec_pkg::COL_W-1:0]  e_rdata_reg;
    logic [vec_pkg::VTX_W-1:0]  n_rdata_reg;
    logic [vec_pkg::COL_W-1:0]  f_rdata_reg;
    logic [vec_pkg::FAN_DW-1:0] fan_rdata_reg;
    logic                       s_rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.e_we) begin
            e_mem[req.e_waddr] <= req.e_wdata;
        end
        if (req.e_re) begin
            e_rdata_reg <= e_mem[req.e_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.n_we) begin
            n_mem[req.n_waddr] <= req.n_wdata;
        end
        if (req.n_re) begin
            n_rdata_reg <= n_mem[req.n_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.f_we) begin
            f_mem[req.f_waddr] <= req.f_wdata;
        end
        if (req.f_re) begin
            f_rdata_reg <= f_mem[req.f_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.fan_we) begin
            fan_mem[req.fan_waddr] <= req.fan_wdata;
        end
        if (req.fan_re) begin
            fan_rdata_reg <= fan_mem[req.fan_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.s_we) begin
            s_mem[req.s_waddr] <= req.s_wdata;
        end
        if (req.s_re) begin
            s_rdata_reg <= s_mem[req.s_raddr];
        end
    end

    assign rsp.e_rdata   = e_rdata_reg;
    assign rsp.n_rdata   = n_rdata_reg;
    assign rsp.f_rdata   = f_rdata_reg;
    assign rsp.fan_rdata = fan_rdata_reg;
    assign rsp.s_rdata   = s_rdata_reg;

endmodule

### hw/rtl/vec_seq.sv
// Sequencer: fan build, alternating path flip and recolouring over the memories.
module vec_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [vec_pkg::VTX_W-1:0]   num_vertices,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_mode,
    input  logic [vec_pkg::VTX_W-1:0]   in_first,
    input  logic [vec_pkg::VTX_W-1:0]   in_second,
    input  logic                        out_free,
    output vec_pkg::vec_res_t           res,
    output vec_pkg::vec_mem_req_t       req,
    input  vec_pkg::vec_mem_rsp_t       rsp
);

    localparam logic [vec_pkg::VTX_W-1:0]   LIM_MAX  = vec_pkg::VTX_W'(vec_pkg::MAX_VERTICES);
    localparam logic [vec_pkg::COL_W-1:0]   COL_TOP  = vec_pkg::COL_W'(vec_pkg::TOP_COLOR);
    localparam logic [vec_pkg::SMALL_AW-1:0] FAN_TOP = vec_pkg::SMALL_AW'(vec_pkg::FAN_MAX);
    localparam logic [vec_pkg::TRIES_W-1:0] TRY_TOP  = vec_pkg::TRIES_W'(vec_pkg::TRIES_MAX);
    localparam logic [vec_pkg::STEPS_W-1:0] STEP_TOP = vec_pkg::STEPS_W'(vec_pkg::STEPS_MAX);

    vec_pkg::vec_state_t   state_reg, state_next;
    vec_pkg::vec_mode_t    mode_reg, mode_next;
    vec_pkg::vec_pb_kind_t kind_reg, kind_next;

    logic [vec_pkg::VTX_W-1:0]    u_reg, u_next, w_reg, w_next, v_reg, v_next;
    logic [vec_pkg::VTX_W-1:0]    pv_reg, pv_next, x_reg, x_next, nud_reg, nud_next;
    logic [vec_pkg::VTX_W-1:0]    a_reg, a_next, b_reg, b_next;
    logic [vec_pkg::COL_W-1:0]    c_reg, c_next, c0_reg, c0_next, d_reg, d_next;
    logic [vec_pkg::COL_W-1:0]    p_reg, p_next, pc_reg, pc_next, rc_reg, rc_next;
    logic [vec_pkg::COL_W-1:0]    color_reg, color_next, highest_reg, highest_next;
    logic [vec_pkg::SMALL_AW-1:0] n_reg, n_next, k_reg, k_next;
    logic [vec_pkg::TRIES_W-1:0]  tries_reg, tries_next;
    logic [vec_pkg::STEPS_W-1:0]  steps_reg, steps_next;
    logic [vec_pkg::PAIR_AW-1:0]  sw_reg, sw_next;
    logic                         phase_reg, phase_next, clr_reg, clr_next;
    logic                         status_reg, status_next;

    logic [vec_pkg::VTX_W-1:0] lim;
    logic                      bad;
    logic [vec_pkg::VTX_W-1:0] fan_v;
    logic [vec_pkg::COL_W-1:0] fan_c;
    logic                      sweep_end;
    logic                      edge_mode;

    assign lim       = (num_vertices > LIM_MAX) ? LIM_MAX : num_vertices;
    assign bad       = (u_reg == '0) || (w_reg == '0) || (u_reg > lim) || (w_reg > lim)
                       || (u_reg == w_reg);
    assign fan_v     = rsp.fan_rdata[vec_pkg::FAN_DW-1:vec_pkg::COL_W];
    assign fan_c     = rsp.fan_rdata[vec_pkg::COL_W-1:0];
    assign sweep_end = (sw_reg == '1);
    assign edge_mode = (mode_reg == vec_pkg::MODE_ADD) || (mode_reg == vec_pkg::MODE_QUERY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vec_pkg::ST_SWEEP;
            sw_reg      <= '0;
            highest_reg <= '0;
            n_reg       <= '0;
            clr_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sw_reg      <= sw_next;
            highest_reg <= highest_next;
            n_reg       <= n_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        kind_reg   <= kind_next;
        u_reg      <= u_next;
        w_reg      <= w_next;
        v_reg      <= v_next;
        pv_reg     <= pv_next;
        x_reg      <= x_next;
        nud_reg    <= nud_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        c0_reg     <= c0_next;
        d_reg      <= d_next;
        p_reg      <= p_next;
        pc_reg     <= pc_next;
        rc_reg     <= rc_next;
        color_reg  <= color_next;
        k_reg      <= k_next;
        tries_reg  <= tries_next;
        steps_reg  <= steps_next;
        phase_reg  <= phase_next;
        status_reg <= status_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vec_pkg::ST_SWEEP: begin
                if (sweep_end) begin
                    state_next = clr_reg ? vec_pkg::ST_DONE : vec_pkg::ST_IDLE;
                end
            end
            vec_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = vec_pkg::ST_DECODE;
                end
            end
            vec_pkg::ST_DECODE: begin
                if (mode_reg == vec_pkg::MODE_CLEAR) begin
                    state_next = vec_pkg::ST_SWEEP;
                end else if (edge_mode && !bad) begin
                    state_next = vec_pkg::ST_TOP_CHK;
                end else begin
                    state_next = vec_pkg::ST_DONE;
                end
            end
            vec_pkg::ST_TOP_CHK: begin
                if (mode_reg == vec_pkg::MODE_ADD && rsp.e_rdata == '0) begin
                    state_next = vec_pkg::ST_TRY;
                end else begin
                    state_next = vec_pkg::ST_DONE;
                end
            end
            vec_pkg::ST_TRY: begin
                if (tries_reg == TRY_TOP) begin
                    state_next = vec_pkg::ST_FINAL;
                end else if (n_reg == '0) begin
                    state_next = vec_pkg::ST_TRY_F;
                end else begin
                    state_next = vec_pkg::ST_UNDO_R;
                end
            end
            vec_pkg::ST_UNDO_R: state_next = vec_pkg::ST_UNDO_W;
            vec_pkg::ST_UNDO_W: begin
                state_next = (k_reg + 1'b1 == n_reg) ? vec_pkg::ST_TRY_F : vec_pkg::ST_UNDO_R;
            end
            vec_pkg::ST_TRY_F:  state_next = vec_pkg::ST_TRY_F2;
            vec_pkg::ST_TRY_F2: state_next = vec_pkg::ST_FAN_E;
            vec_pkg::ST_FAN_E:  state_next = vec_pkg::ST_FAN_E2;
            vec_pkg::ST_FAN_E2: begin
                if (rsp.e_rdata != '0) begin
                    state_next = vec_pkg::ST_FINAL;
                end else if (n_reg >= FAN_TOP) begin
                    state_next = vec_pkg::ST_FLIP;
                end else begin
                    state_next = vec_pkg::ST_FAN_D;
                end
            end
            vec_pkg::ST_FAN_D:  state_next = vec_pkg::ST_FAN_D2;
            vec_pkg::ST_FAN_D2: state_next = vec_pkg::ST_FAN_N1;
            vec_pkg::ST_FAN_N1: begin
                state_next = (rsp.n_rdata == '0) ? vec_pkg::ST_PB_R : vec_pkg::ST_FAN_N2;
            end
            vec_pkg::ST_FAN_N2: begin
                state_next = (rsp.n_rdata == '0) ? vec_pkg::ST_PB_R : vec_pkg::ST_FAN_S;
            end
            vec_pkg::ST_FAN_S: begin
                state_next = rsp.s_rdata ? vec_pkg::ST_FLIP : vec_pkg::ST_FAN_E;
            end
            vec_pkg::ST_PB_R:  state_next = vec_pkg::ST_PB_C;
            vec_pkg::ST_PB_C:  state_next = vec_pkg::ST_P_RD;
            vec_pkg::ST_P_RD:  state_next = vec_pkg::ST_P_E1;
            vec_pkg::ST_P_E1:  state_next = vec_pkg::ST_P_E2;
            vec_pkg::ST_P_E2:  state_next = vec_pkg::ST_P_N1;
            vec_pkg::ST_P_N1:  state_next = vec_pkg::ST_P_N2;
            vec_pkg::ST_P_N2:  state_next = vec_pkg::ST_P_N3;
            vec_pkg::ST_P_N3:  state_next = vec_pkg::ST_P_N4;
            vec_pkg::ST_P_N4: begin
                state_next = (p_reg != '0) ? vec_pkg::ST_P_F1 : vec_pkg::ST_R_CHK;
            end
            vec_pkg::ST_P_F1:  state_next = vec_pkg::ST_P_F2;
            vec_pkg::ST_P_F2:  state_next = vec_pkg::ST_PB_RET;
            vec_pkg::ST_R_CHK: begin
                state_next = (rc_reg == COL_TOP) ? vec_pkg::ST_R_W : vec_pkg::ST_R_D;
            end
            vec_pkg::ST_R_D: begin
                state_next = (rsp.n_rdata != '0) ? vec_pkg::ST_R_CHK : vec_pkg::ST_R_W;
            end
            vec_pkg::ST_R_W: begin
                state_next = phase_reg ? vec_pkg::ST_PB_RET : vec_pkg::ST_R_CHK;
            end
            vec_pkg::ST_PB_RET: begin
                if (k_reg != '0) begin
                    state_next = vec_pkg::ST_PB_R;
                end else if (kind_reg == vec_pkg::PB_LAST) begin
                    state_next = vec_pkg::ST_FINAL;
                end else begin
                    state_next = vec_pkg::ST_FAN_E;
                end
            end
            vec_pkg::ST_FLIP:   state_next = vec_pkg::ST_FL_CHK;
            vec_pkg::ST_FL_CHK: begin
                if (v_reg == '0 || steps_reg == STEP_TOP) begin
                    state_next = vec_pkg::ST_AFT;
                end else begin
                    state_next = vec_pkg::ST_FL_A;
                end
            end
            vec_pkg::ST_FL_A:  state_next = vec_pkg::ST_FL_B;
            vec_pkg::ST_FL_B:  state_next = vec_pkg::ST_FL_W2;
            vec_pkg::ST_FL_W2: begin
                state_next = (a_reg != '0) ? vec_pkg::ST_FL_E1 : vec_pkg::ST_FL_CHK;
            end
            vec_pkg::ST_FL_E1: state_next = vec_pkg::ST_FL_E2;
            vec_pkg::ST_FL_E2: state_next = vec_pkg::ST_FL_CHK;
            vec_pkg::ST_AFT:   state_next = vec_pkg::ST_AFT2;
            vec_pkg::ST_AFT2: begin
                if (rsp.n_rdata == '0) begin
                    state_next = vec_pkg::ST_TRY;
                end else if (n_reg < 9'd2) begin
                    state_next = vec_pkg::ST_FINAL;
                end else begin
                    state_next = vec_pkg::ST_SR_R;
                end
            end
            vec_pkg::ST_SR_R: state_next = vec_pkg::ST_SR_C;
            vec_pkg::ST_SR_C: begin
                if (fan_c == c_reg) begin
                    state_next = vec_pkg::ST_PB_C;
                end else if (k_reg == '0) begin
                    state_next = vec_pkg::ST_FINAL;
                end else begin
                    state_next = vec_pkg::ST_SR_R;
                end
            end
            vec_pkg::ST_FINAL: state_next = vec_pkg::ST_FIN2;
            vec_pkg::ST_FIN2:  state_next = vec_pkg::ST_DONE;
            vec_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = vec_pkg::ST_IDLE;
                end
            end
            default: state_next = vec_pkg::ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        mode_next    = mode_reg;
        kind_next    = kind_reg;
        u_next       = u_reg;
        w_next       = w_reg;
        v_next       = v_reg;
        pv_next      = pv_reg;
        x_next       = x_reg;
        nud_next     = nud_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        c0_next      = c0_reg;
        d_next       = d_reg;
        p_next       = p_reg;
        pc_next      = pc_reg;
        rc_next      = rc_reg;
        color_next   = color_reg;
        highest_next = highest_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        tries_next   = tries_reg;
        steps_next   = steps_reg;
        sw_next      = sw_reg;
        phase_next   = phase_reg;
        clr_next     = clr_reg;
        status_next  = status_reg;
        case (state_reg)
            vec_pkg::ST_SWEEP: begin
                sw_next = sw_reg + 1'b1;
            end
            vec_pkg::ST_IDLE: begin
                mode_next = vec_pkg::vec_mode_t'(in_mode);
                u_next    = in_first;
                w_next    = in_second;
            end
            vec_pkg::ST_DECODE: begin
                clr_next    = (mode_reg == vec_pkg::MODE_CLEAR);
                color_next  = '0;
                status_next = edge_mode && bad;
                if (mode_reg == vec_pkg::MODE_CLEAR) begin
                    highest_next = '0;
                    n_next       = '0;
                    sw_next      = '0;
                end
            end
            vec_pkg::ST_TOP_CHK: begin
                color_next = rsp.e_rdata;
                tries_next = '0;
            end
            vec_pkg::ST_TRY:    k_next = '0;
            vec_pkg::ST_UNDO_W: k_next = k_reg + 1'b1;
            vec_pkg::ST_TRY_F2: begin
                c_next  = rsp.f_rdata;
                c0_next = rsp.f_rdata;
                v_next  = w_reg;
                d_next  = '0;
                n_next  = '0;
            end
            vec_pkg::ST_FAN_D2: begin
                d_next = rsp.f_rdata;
                n_next = n_reg + 1'b1;
            end
            vec_pkg::ST_FAN_N1: begin
                kind_next = vec_pkg::PB_CHAIN;
                k_next    = n_reg - 1'b1;
            end
            vec_pkg::ST_FAN_N2: begin
                nud_next  = rsp.n_rdata;
                kind_next = vec_pkg::PB_FAN;
                k_next    = n_reg - 1'b1;
            end
            vec_pkg::ST_FAN_S: begin
                if (!rsp.s_rdata) begin
                    v_next = nud_reg;
                end
            end
            vec_pkg::ST_PB_C: begin
                pv_next = fan_v;
                pc_next = (kind_reg == vec_pkg::PB_CHAIN) ? c_reg : fan_c;
            end
            vec_pkg::ST_P_E1: begin
                p_next = rsp.e_rdata;
                if (pc_reg > highest_reg) begin
                    highest_next = pc_reg;
                end
            end
            vec_pkg::ST_P_N4: begin
                x_next     = u_reg;
                phase_next = 1'b0;
                rc_next    = 9'd1;
            end
            vec_pkg::ST_R_D: begin
                if (rsp.n_rdata != '0) begin
                    rc_next = rc_reg + 1'b1;
                end
            end
            vec_pkg::ST_R_W: begin
                x_next     = pv_reg;
                phase_next = 1'b1;
                rc_next    = 9'd1;
            end
            vec_pkg::ST_PB_RET: begin
                if (kind_reg == vec_pkg::PB_CHAIN) begin
                    c_next = p_reg;
                end
                if (k_reg != '0) begin
                    k_next = k_reg - 1'b1;
                end
            end
            vec_pkg::ST_FLIP: steps_next = '0;
            vec_pkg::ST_FL_A: a_next = rsp.n_rdata;
            vec_pkg::ST_FL_B: b_next = rsp.n_rdata;
            vec_pkg::ST_FL_W2, vec_pkg::ST_FL_E2: begin
                if (state_reg == vec_pkg::ST_FL_E2 || a_reg == '0) begin
                    c_next     = d_reg;
                    d_next     = c_reg;
                    v_next     = a_reg;
                    steps_next = steps_reg + 1'b1;
                end
            end
            vec_pkg::ST_AFT2: begin
                if (rsp.n_rdata == '0) begin
                    tries_next = tries_reg + 1'b1;
                end else begin
                    k_next = n_reg - 9'd2;
                end
            end
            vec_pkg::ST_SR_C: begin
                kind_next = vec_pkg::PB_LAST;
                if (fan_c != c_reg && k_reg != '0) begin
                    k_next = k_reg - 1'b1;
                end
            end
            vec_pkg::ST_FIN2: color_next = rsp.e_rdata;
            default: begin
            end
        endcase
    end

    // memory requests and handshake outputs
    always_comb begin
        req = '0;
        case (state_reg)
            vec_pkg::ST_SWEEP: begin
                req.e_we    = 1'b1;
                req.e_waddr = sw_reg;
                req.n_we    = 1'b1;
                req.n_waddr = sw_reg;
                req.f_we    = 1'b1;
                req.f_waddr = sw_reg[vec_pkg::SMALL_AW-1:0];
                req.f_wdata = 9'd1;
                req.s_we    = 1'b1;
                req.s_waddr = sw_reg[vec_pkg::SMALL_AW-1:0];
            end
            vec_pkg::ST_DECODE, vec_pkg::ST_FAN_E, vec_pkg::ST_FINAL: begin
                req.e_re    = 1'b1;
                req.e_raddr = vec_pkg::pair_addr(u_reg, w_reg);
            end
            vec_pkg::ST_UNDO_R, vec_pkg::ST_PB_R, vec_pkg::ST_SR_R: begin
                req.fan_re    = 1'b1;
                req.fan_raddr = k_reg;
            end
            vec_pkg::ST_UNDO_W: begin
                req.s_we    = 1'b1;
                req.s_waddr = fan_c;
            end
            vec_pkg::ST_TRY_F: begin
                req.f_re    = 1'b1;
                req.f_raddr = u_reg;
            end
            vec_pkg::ST_FAN_D: begin
                req.f_re    = 1'b1;
                req.f_raddr = v_reg;
            end
            vec_pkg::ST_FAN_D2: begin
                req.fan_we    = 1'b1;
                req.fan_waddr = n_reg;
                req.fan_wdata = {v_reg, rsp.f_rdata};
                req.n_re      = 1'b1;
                req.n_raddr   = vec_pkg::pair_addr(v_reg, c_reg);
            end
            vec_pkg::ST_FAN_N1: begin
                req.n_re    = 1'b1;
                req.n_raddr = vec_pkg::pair_addr(u_reg, d_reg);
            end
            vec_pkg::ST_FAN_N2: begin
                req.s_re    = 1'b1;
                req.s_raddr = d_reg;
            end
            vec_pkg::ST_FAN_S: begin
                req.s_we    = !rsp.s_rdata;
                req.s_waddr = d_reg;
                req.s_wdata = 1'b1;
            end
            vec_pkg::ST_P_RD: begin
                req.e_re    = 1'b1;
                req.e_raddr = vec_pkg::pair_addr(u_reg, pv_reg);
            end
            vec_pkg::ST_P_E1: begin
                req.e_we    = 1'b1;
                req.e_waddr = vec_pkg::pair_addr(u_reg, pv_reg);
                req.e_wdata = pc_reg;
            end
            vec_pkg::ST_P_E2: begin
                req.e_we    = 1'b1;
                req.e_waddr = vec_pkg::pair_addr(pv_reg, u_reg);
                req.e_wdata = pc_reg;
            end
            vec_pkg::ST_P_N1: begin
                req.n_we    = 1'b1;
                req.n_waddr = vec_pkg::pair_addr(u_reg, pc_reg);
                req.n_wdata = pv_reg;
            end
            vec_pkg::ST_P_N2: begin
                req.n_we    = 1'b1;
                req.n_waddr = vec_pkg::pair_addr(pv_reg, pc_reg);
                req.n_wdata = u_reg;
            end
            vec_pkg::ST_P_N3: begin
                req.n_we    = 1'b1;
                req.n_waddr = vec_pkg::pair_addr(u_reg, p_reg);
            end
            vec_pkg::ST_P_N4: begin
                req.n_we    = 1'b1;
                req.n_waddr = vec_pkg::pair_addr(pv_reg, p_reg);
            end
            vec_pkg::ST_P_F1: begin
                req.f_we    = 1'b1;
                req.f_waddr = u_reg;
                req.f_wdata = p_reg;
            end
            vec_pkg::ST_P_F2: begin
                req.f_we    = 1'b1;
                req.f_waddr = pv_reg;
                req.f_wdata = p_reg;
            end
            vec_pkg::ST_R_CHK: begin
                req.n_re    = (rc_reg != COL_TOP);
                req.n_raddr = vec_pkg::pair_addr(x_reg, rc_reg);
            end
            vec_pkg::ST_R_W: begin
                req.f_we    = 1'b1;
                req.f_waddr = x_reg;
                req.f_wdata = rc_reg;
            end
            vec_pkg::ST_FL_CHK: begin
                req.n_re    = 1'b1;
                req.n_raddr = vec_pkg::pair_addr(v_reg, c_reg);
            end
            vec_pkg::ST_FL_A: begin
                req.n_re    = 1'b1;
                req.n_raddr = vec_pkg::pair_addr(v_reg, d_reg);
            end
            vec_pkg::ST_FL_B: begin
                req.n_we    = 1'b1;
                req.n_waddr = vec_pkg::pair_addr(v_reg, c_reg);
                req.n_wdata = rsp.n_rdata;
            end
            vec_pkg::ST_FL_W2: begin
                req.n_we    = 1'b1;
                req.n_waddr = vec_pkg::pair_addr(v_reg, d_reg);
                req.n_wdata = a_reg;
                // a missing old edge frees d; failing that a missing partner frees c
                req.f_we    = (a_reg == '0) || (b_reg == '0);
                req.f_waddr = v_reg;
                req.f_wdata = (a_reg == '0) ? d_reg : c_reg;
            end
            vec_pkg::ST_FL_E1: begin
                req.e_we    = 1'b1;
                req.e_waddr = vec_pkg::pair_addr(v_reg, a_reg);
                req.e_wdata = d_reg;
            end
            vec_pkg::ST_FL_E2: begin
                req.e_we    = 1'b1;
                req.e_waddr = vec_pkg::pair_addr(a_reg, v_reg);
                req.e_wdata = d_reg;
            end
            vec_pkg::ST_AFT: begin
                req.n_re    = 1'b1;
                req.n_raddr = vec_pkg::pair_addr(u_reg, c0_reg);
            end
            default: begin
            end
        endcase
    end

    assign in_ready      = (state_reg == vec_pkg::ST_IDLE);
    assign res.valid     = (state_reg == vec_pkg::ST_DONE) && out_free;
    assign res.color     = color_reg;
    assign res.max_color = highest_reg;
    assign res.status    = status_reg;

endmodule

### hw/rtl/vizing_edge_colorer.sv
// Top level of the online edge colorer: config register, sequencer, memories, result register.
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+-----------------------------------------
//  s_       | in  | s_tvalid/s_tready  | mode in tuser, vertex pair in tdata
//  m_       | out | m_tvalid/m_tready  | edge colour, max colour; status in tuser
//  cfg_     | in  | cfg_wr_en          | num_vertices
//
// After reset and after every clear the stores are swept, one entry a cycle.
// A query passes through the decode and top-check states to the done state, where its result
// is registered; a rejected item or an unused mode goes from decode straight to done.
// The time an added edge takes is set by the sequential read-modify-write walks over the edge,
// neighbour and free-colour memories (one access per memory per cycle). One item is in work at a
// time; a finished result waits in the output register while the next item is accepted, and a
// second result stalls until it is taken.
module vizing_edge_colorer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [8:0] first_vertex, [17:9] second_vertex, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [8:0] edge_color, [17:9] max_color, rest zero
    output logic        m_tuser    // [0] status
);

    logic [vec_pkg::VTX_W-1:0] num_vertices_reg;
    logic                      m_valid_reg;
    logic [vec_pkg::COL_W-1:0] m_color_reg;
    logic [vec_pkg::COL_W-1:0] m_max_reg;
    logic                      m_status_reg;
    logic                      out_free;

    vec_pkg::vec_res_t     res;
    vec_pkg::vec_mem_req_t req;
    vec_pkg::vec_mem_rsp_t rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vertices_reg <= vec_pkg::VTX_W'(vec_pkg::MAX_VERTICES);
        end else if (cfg_wr_en) begin
            num_vertices_reg <= cfg_wr_data;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_color_reg  <= res.color;
            m_max_reg    <= res.max_color;
            m_status_reg <= res.status;
        end
    end

    vec_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .num_vertices (num_vertices_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_mode      (s_tuser),
        .in_first     (s_tdata[8:0]),
        .in_second    (s_tdata[17:9]),
        .out_free     (out_free),
        .res          (res),
        .req          (req),
        .rsp          (rsp)
    );

    vec_mem u_mem (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_max_reg, m_color_reg};
    assign m_tuser  = m_status_reg;

endmodule

### hw/rtl/vec_checker.sv
// Port-level checker for the edge colorer, bound to the top level.
`include "assert_macros.svh"

module vec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [8:0]  cfg_wr_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    logic        m_stall;
    logic [25:0] m_word;

    assign m_stall = m_tvalid && !m_tready;
    assign m_word  = {m_tvalid, m_tuser, m_tdata};

    // a stalled result transaction holds
    `VEC_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, $stable(m_word))
    // a rejected pair carries no colour
    `VEC_ASSERT_NOW(a_bad_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata[8:0] == 9'd0)
    // padding above the two colours stays zero
    `VEC_ASSERT_NOW(a_pad, aclk, aresetn, m_tvalid, m_tdata[23:18] == 6'd0)
    // the maximum colour stays at or below 257
    `VEC_ASSERT_NOW(a_max_rng, aclk, aresetn, m_tvalid, m_tdata[17:9] <= 9'd257)

endmodule

bind vizing_edge_colorer vec_checker u_vec_checker (.*);
